FILE: design/hic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hic_pkg: shared types and constants for the compass heading block
// Action codes, sequencer states, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package hic_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACT_W            = 2;
    localparam int HEAD_W           = 13;
    localparam int CORDIC_STEPS     = 18;
    localparam int STEP_W           = $clog2(CORDIC_STEPS);
    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_GUARD     = 4;    // CORDIC gain plus vector length
    localparam int ANG_W            = 20;   // 1/4096 degree, sum of table < 2^19
    localparam int H_CALC_W         = 22;
    localparam int ROUND_SHIFT      = 8;    // 1/4096 deg -> 1/16 deg
    localparam int HEADING_MAX      = 5760;
    localparam int HEADING_SOUTH    = 2880;

    localparam logic [ACT_W-1:0] ACT_ACQUIRE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CALIBRATE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN       = 2'd2;

    // base angle plus half an output LSB for rounding
    localparam logic signed [H_CALC_W-1:0] H_BASE_POS =
        H_CALC_W'(90 * 4096 + (1 << (ROUND_SHIFT - 1)));
    localparam logic signed [H_CALC_W-1:0] H_BASE_NEG =
        H_CALC_W'(270 * 4096 + (1 << (ROUND_SHIFT - 1)));
    localparam logic signed [H_CALC_W-1:0] H_MAX_EXT = H_CALC_W'(HEADING_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_ROT,
        ST_FIN
    } hic_state_t;

    typedef struct packed {
        logic acquire;
        logic calibrate;
    } calib_ctl_t;

    // round(atan(2^-i) * 57.29 * 4096)
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = 20'sd184301;
            5'd1:    val = 20'sd108799;
            5'd2:    val = 20'sd57487;
            5'd3:    val = 20'sd29181;
            5'd4:    val = 20'sd14647;
            5'd5:    val = 20'sd7331;
            5'd6:    val = 20'sd3666;
            5'd7:    val = 20'sd1833;
            5'd8:    val = 20'sd917;
            5'd9:    val = 20'sd458;
            5'd10:   val = 20'sd229;
            5'd11:   val = 20'sd115;
            5'd12:   val = 20'sd57;
            5'd13:   val = 20'sd29;
            5'd14:   val = 20'sd14;
            5'd15:   val = 20'sd7;
            5'd16:   val = 20'sd4;
            5'd17:   val = 20'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: design/hic_calib.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hic_calib: hard-iron calibration state
// Per-axis running max/min and the midpoint offsets derived from them.
// ----------------------------------------------------------------------------
module hic_calib #(
    parameter int SAMPLE_WIDTH = hic_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hic_pkg::calib_ctl_t            ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] smp_x,
    input  logic signed [SAMPLE_WIDTH-1:0] smp_y,
    input  logic signed [SAMPLE_WIDTH-1:0] smp_z,
    output logic signed [SAMPLE_WIDTH-1:0] off_x,
    output logic signed [SAMPLE_WIDTH-1:0] off_y,
    output logic signed [SAMPLE_WIDTH-1:0] off_z
);
    import hic_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic signed [SW-1:0] max_reg [3];
    logic signed [SW-1:0] min_reg [3];
    logic signed [SW-1:0] off_reg [3];
    logic signed [SW-1:0] max_next [3];
    logic signed [SW-1:0] min_next [3];
    logic signed [SW-1:0] off_next [3];
    logic signed [SW-1:0] smp [3];
    logic signed [SW:0]   sum [3];
    logic signed [SW:0]   rnd [3];
    logic signed [SW:0]   half [3];

    assign smp[0] = smp_x;
    assign smp[1] = smp_y;
    assign smp[2] = smp_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            max_next[k] = max_reg[k];
            min_next[k] = min_reg[k];
            off_next[k] = off_reg[k];
            // midpoint, truncated toward zero
            sum[k]  = {max_reg[k][SW-1], max_reg[k]} + {min_reg[k][SW-1], min_reg[k]};
            rnd[k]  = sum[k] + $signed({{SW{1'b0}}, sum[k][SW]});
            half[k] = rnd[k] >>> 1;
            if (ctl.acquire) begin
                priority if (max_reg[k] == '0 && min_reg[k] == '0) begin
                    max_next[k] = smp[k];
                    min_next[k] = smp[k];
                end else if (smp[k] > max_reg[k]) begin
                    max_next[k] = smp[k];
                end else if (smp[k] < min_reg[k]) begin
                    min_next[k] = smp[k];
                end else begin
                    // inside the range: nothing moves
                    max_next[k] = max_reg[k];
                end
            end
            if (ctl.calibrate) begin
                off_next[k] = half[k][SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (!aresetn) begin
                max_reg[k] <= '0;
                min_reg[k] <= '0;
                off_reg[k] <= '0;
            end else begin
                max_reg[k] <= max_next[k];
                min_reg[k] <= min_next[k];
                off_reg[k] <= off_next[k];
            end
        end
    end

    assign off_x = off_reg[0];
    assign off_y = off_reg[1];
    assign off_z = off_reg[2];

endmodule

FILE: design/hic_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hic_cordic: iterative CORDIC vectoring engine
// One shared add/sub/shift step reused over all iterations, angle in 1/4096 deg.
// ----------------------------------------------------------------------------
module hic_cordic #(
    parameter int SAMPLE_WIDTH = hic_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [SAMPLE_WIDTH:0]      cx,
    input  logic signed [SAMPLE_WIDTH:0]      cy,
    output logic                              last,
    output logic signed [hic_pkg::ANG_W-1:0]  ang
);
    import hic_pkg::*;

    localparam int CAL_W = SAMPLE_WIDTH + 1;
    localparam int CW    = CAL_W + FRAC_BITS + CORDIC_GUARD;

    logic                    busy_reg, busy_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [CW-1:0]    xv_reg, xv_next;
    logic signed [CW-1:0]    yv_reg, yv_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;

    logic signed [CAL_W-1:0] cy_abs;
    logic signed [CW-1:0]    x_init, y_init;
    logic signed [CW-1:0]    dx, dy;
    logic signed [ANG_W-1:0] tab;

    assign cy_abs = cy[CAL_W-1] ? -cy : cy;
    assign x_init = {{(CW-CAL_W){cy_abs[CAL_W-1]}}, cy_abs} <<< FRAC_BITS;
    assign y_init = {{(CW-CAL_W){cx[CAL_W-1]}}, cx} <<< FRAC_BITS;

    assign dx  = yv_reg >>> step_reg;
    assign dy  = xv_reg >>> step_reg;
    assign tab = atan_lut(step_reg);

    assign last = busy_reg && (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        xv_next   = xv_reg;
        yv_next   = yv_reg;
        ang_next  = ang_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            xv_next   = x_init;
            yv_next   = y_init;
            ang_next  = '0;
        end else if (busy_reg) begin
            if (!yv_reg[CW-1]) begin
                xv_next  = xv_reg + dx;
                yv_next  = yv_reg - dy;
                ang_next = ang_reg + tab;
            end else begin
                xv_next  = xv_reg - dx;
                yv_next  = yv_reg + dy;
                ang_next = ang_reg - tab;
            end
            if (last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        xv_reg  <= xv_next;
        yv_reg  <= yv_next;
        ang_reg <= ang_next;
    end

    assign ang = ang_reg;

endmodule

FILE: design/hard_iron_compass_heading_top.sv
`timescale 1ns / 1ps
// Sequence per input beat: a run beat with nonzero calibrated Y passes the setup states
//   EXEC and LOAD, 18 CORDIC iterations on one shared step unit in ROT, then FIN; a run
//   beat with zero calibrated Y skips ROT; other actions pass only EXEC and FIN.
// One beat in work at a time: a new beat is taken only in the idle state. A result
//   stalled in the output register keeps the beat behind it waiting in FIN.
// Reset: aresetn synchronous active low; clears max/min/offsets to zero and idles the sequencer.
// ----------------------------------------------------------------------------
// hard_iron_compass_heading_top: hard-iron calibrated compass heading
// Tracks per-axis min/max, derives offsets, and converts calibrated X/Y to a
// heading in 1/16 degree via an iterative CORDIC vectoring engine.
// ----------------------------------------------------------------------------
module hard_iron_compass_heading_top #(
    parameter int SAMPLE_WIDTH = hic_pkg::SAMPLE_WIDTH_DEF,
    localparam int S_DATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((hic_pkg::HEAD_W + 3 * (SAMPLE_WIDTH + 1) + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beat
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_W-1:0]         s_tdata,   // x_sample, y_sample, z_sample
    input  logic [hic_pkg::ACT_W-1:0]   s_tuser,   // action
    // result beat
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // heading, cal_x, cal_y, cal_z
    output logic [0:0]                  m_tuser    // heading_valid
);
    import hic_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CAL_W = SAMPLE_WIDTH + 1;

    hic_state_t state_reg, state_next;

    // captured input beat
    logic [ACT_W-1:0]        act_reg;
    logic signed [SW-1:0]    smp_x_reg, smp_y_reg, smp_z_reg;
    // calibrated sample
    logic signed [CAL_W-1:0] cal_x_reg, cal_y_reg, cal_z_reg;

    // output register
    logic                    m_tvalid_reg;
    logic [HEAD_W-1:0]       m_head_reg;
    logic                    m_hv_reg;
    logic signed [CAL_W-1:0] m_cx_reg, m_cy_reg, m_cz_reg;

    logic                    s_acc;
    logic                    out_free;
    logic                    out_load;
    logic                    is_run;
    logic                    cordic_start;
    logic                    cordic_last;
    calib_ctl_t              calib_ctl;
    logic signed [SW-1:0]    off_x, off_y, off_z;
    logic signed [ANG_W-1:0] ang;

    logic signed [H_CALC_W-1:0] ang_ext;
    logic signed [H_CALC_W-1:0] h_sum;
    logic signed [H_CALC_W-1:0] h_shr;
    logic [HEAD_W-1:0]          h_sat;
    logic [HEAD_W-1:0]          res_head;
    logic                       res_hv;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_run   = (act_reg == ACT_RUN);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_EXEC;
            ST_EXEC: state_next = is_run ? ST_LOAD : ST_FIN;
            // zero calibrated Y takes the due north/south shortcut
            ST_LOAD: state_next = (cal_y_reg != '0) ? ST_ROT : ST_FIN;
            ST_ROT:  if (cordic_last) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready            = (state_reg == ST_IDLE);
        calib_ctl.acquire   = (state_reg == ST_EXEC) && (act_reg == ACT_ACQUIRE);
        calib_ctl.calibrate = (state_reg == ST_EXEC) && (act_reg == ACT_CALIBRATE);
        cordic_start        = (state_reg == ST_LOAD) && (cal_y_reg != '0);
        out_load            = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- input capture and offset removal ----------------
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            act_reg   <= s_tuser;
            smp_x_reg <= s_tdata[SW-1:0];
            smp_y_reg <= s_tdata[2*SW-1:SW];
            smp_z_reg <= s_tdata[3*SW-1:2*SW];
        end
        if (state_reg == ST_EXEC) begin
            cal_x_reg <= {smp_x_reg[SW-1], smp_x_reg} - {off_x[SW-1], off_x};
            cal_y_reg <= {smp_y_reg[SW-1], smp_y_reg} - {off_y[SW-1], off_y};
            cal_z_reg <= {smp_z_reg[SW-1], smp_z_reg} - {off_z[SW-1], off_z};
        end
    end

    hic_calib #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_calib (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (calib_ctl),
        .smp_x   (smp_x_reg),
        .smp_y   (smp_y_reg),
        .smp_z   (smp_z_reg),
        .off_x   (off_x),
        .off_y   (off_y),
        .off_z   (off_z)
    );

    hic_cordic #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .cx      (cal_x_reg),
        .cy      (cal_y_reg),
        .last    (cordic_last),
        .ang     (ang)
    );

    // ---------------- heading finish ----------------
    // north-referenced: 90 - a for +Y, 270 + a for -Y, rounded to 1/16 deg
    assign ang_ext = {{(H_CALC_W-ANG_W){ang[ANG_W-1]}}, ang};
    assign h_sum   = cal_y_reg[CAL_W-1] ? (H_BASE_NEG + ang_ext) : (H_BASE_POS - ang_ext);
    assign h_shr   = h_sum >>> ROUND_SHIFT;

    always_comb begin
        priority if (h_shr[H_CALC_W-1]) begin
            h_sat = '0;
        end else if (h_shr > H_MAX_EXT) begin
            h_sat = HEAD_W'(HEADING_MAX);
        end else begin
            h_sat = h_shr[HEAD_W-1:0];
        end
    end

    always_comb begin
        res_head = '0;
        res_hv   = 1'b0;
        if (is_run) begin
            if (cal_y_reg != '0) begin
                res_head = h_sat;
                res_hv   = 1'b1;
            end else if (cal_x_reg != '0) begin
                // on the X axis: due north or due south
                res_head = cal_x_reg[CAL_W-1] ? HEAD_W'(HEADING_SOUTH) : '0;
                res_hv   = 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_head_reg <= res_head;
            m_hv_reg   <= res_hv;
            m_cx_reg   <= is_run ? cal_x_reg : '0;
            m_cy_reg   <= is_run ? cal_y_reg : '0;
            m_cz_reg   <= is_run ? cal_z_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_cz_reg, m_cy_reg, m_cx_reg, m_head_reg});
    assign m_tuser  = m_hv_reg;

endmodule

FILE: design/hic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hic_checker: port-level checks for the compass heading block
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module hic_checker #(
    parameter int SAMPLE_WIDTH = hic_pkg::SAMPLE_WIDTH_DEF,
    localparam int M_DATA_W = ((hic_pkg::HEAD_W + 3 * (SAMPLE_WIDTH + 1) + 7) / 8) * 8
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [M_DATA_W-1:0]       m_tdata,
    input logic [0:0]                m_tuser
);
    import hic_pkg::*;

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one beat in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[HEAD_W-1:0] <= HEAD_W'(HEADING_MAX))
        else $error("heading out of range");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[HEAD_W-1:0] == '0)
        else $error("undefined heading not zero");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind hard_iron_compass_heading_top hic_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_hic_checker (.*);

FILE: tb/hard_iron_compass_heading_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hard_iron_compass_heading_top_test: self-checking bench for the compass block
// Streams acquire / calibrate / run beats through the block, predicts every
// result beat with an in-bench min/max/offset tracker and a CORDIC heading
// model, and checks each result field by field with random idling on both
// sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module hard_iron_compass_heading_top_test;

    import hic_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int CW          = SW + 1;           // calibrated axis width
    localparam int N_PHASES    = 46;               // acquire/calibrate/run rounds
    localparam int HOLD_AT     = 300;              // result count that starts the hold
    localparam int HOLD_CYCLES = 400;              // long receiver hold-off
    localparam int TAIL_CYCLES = 40;               // > run-beat latency

    // unused action code: no state change, all-zero result
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // one input beat; smp[0] = X sits in the low bits, matching s_tdata
    typedef struct packed {
        logic [ACT_W-1:0]     act;
        logic [2:0][SW-1:0]   smp;
    } compass_beat_t;

    // one expected result beat
    typedef struct packed {
        logic [HEAD_W-1:0]    heading;
        logic                 valid;
        logic [CW-1:0]        cal_x;
        logic [CW-1:0]        cal_y;
        logic [CW-1:0]        cal_z;
    } heading_beat_t;

    // per-axis hard-iron tracking state (signed values held as raw bits)
    typedef struct packed {
        logic [SW-1:0] hi;
        logic [SW-1:0] lo;
        logic [SW-1:0] off;
    } axis_cal_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [3*SW-1:0]      s_tdata  = '0;     // x_sample, y_sample, z_sample
    logic [ACT_W-1:0]     s_tuser  = '0;     // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;           // heading, cal_x, cal_y, cal_z
    logic [0:0]           m_tuser;           // heading_valid

    compass_beat_t  pending_q [$];           // beats waiting for the driver
    heading_beat_t  heading_expect_q [$];    // predicted results, oldest first

    axis_cal_t      pred_axis [3];           // tracker state seen by the checker
    axis_cal_t      plan_axis [3];           // same state, as the generator sees it

    int n_queued     = 0;
    int beats_in     = 0;
    int results_seen = 0;
    int n_errors     = 0;

    // driver / monitor private state
    compass_beat_t on_bus;
    int tx_gap   = 0;
    int tx_quiet = 0;
    int rx_stall = 0;
    int rx_quiet = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    hard_iron_compass_heading_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // atan(2^-i) in 1/4096 degree at 57.29 deg/rad
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 184301;
            1:  return 108799;
            2:  return 57487;
            3:  return 29181;
            4:  return 14647;
            5:  return 7331;
            6:  return 3666;
            7:  return 1833;
            8:  return 917;
            9:  return 458;
            10: return 229;
            11: return 115;
            12: return 57;
            13: return 29;
            14: return 14;
            15: return 7;
            16: return 4;
            17: return 2;
            default: return 0;
        endcase
    endfunction

    // acquire widens the range (an empty axis, max = min = 0, takes the
    // sample as both ends); calibrate moves the offset to the midpoint
    function automatic axis_cal_t track_axis(input axis_cal_t a, input logic [ACT_W-1:0] act,
                                             input logic [SW-1:0] s);
        axis_cal_t n;
        n = a;
        if (act == ACT_ACQUIRE) begin
            if (a.hi == '0 && a.lo == '0) begin
                n.hi = s;
                n.lo = s;
            end else if ($signed(s) > $signed(a.hi)) begin
                n.hi = s;
            end else if ($signed(s) < $signed(a.lo)) begin
                n.lo = s;
            end
        end else if (act == ACT_CALIBRATE) begin
            // signed divide truncates toward zero
            n.off = SW'((longint'($signed(a.hi)) + longint'($signed(a.lo))) / 2);
        end
        return n;
    endfunction

    // CORDIC vectoring from (|cy|, cx), heading in 1/16 degree
    function automatic logic [HEAD_W-1:0] cordic_heading(input longint cx, input longint cy);
        longint xv, yv, ang, h, dx, dy;
        int i;
        if (cy == 0)
            return (cx > 0) ? HEAD_W'(0) : HEAD_W'(HEADING_SOUTH);
        xv  = ((cy < 0) ? -cy : cy) * 65536;
        yv  = cx * 65536;
        ang = 0;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv  = xv + dx;
                yv  = yv - dy;
                ang = ang + atan_step(i);
            end else begin
                xv  = xv - dx;
                yv  = yv + dy;
                ang = ang - atan_step(i);
            end
        end
        h = (cy > 0) ? (90 * 4096 - ang) : (270 * 4096 + ang);
        h = (h + 128) >>> 8;
        if (h < 0)
            h = 0;
        if (h > HEADING_MAX)
            h = HEADING_MAX;
        return HEAD_W'(h);
    endfunction

    // called once per accepted input beat
    function automatic void predict_heading_beat(input compass_beat_t b);
        heading_beat_t r;
        longint cx, cy, cz;
        int k;
        r = '0;
        if (b.act == ACT_RUN) begin
            cx = longint'($signed(b.smp[0])) - longint'($signed(pred_axis[0].off));
            cy = longint'($signed(b.smp[1])) - longint'($signed(pred_axis[1].off));
            cz = longint'($signed(b.smp[2])) - longint'($signed(pred_axis[2].off));
            if (cx != 0 || cy != 0) begin
                r.heading = cordic_heading(cx, cy);
                r.valid   = 1'b1;
            end
            r.cal_x = CW'(cx);
            r.cal_y = CW'(cy);
            r.cal_z = CW'(cz);
        end
        for (k = 0; k < 3; k++)
            pred_axis[k] = track_axis(pred_axis[k], b.act, b.smp[k]);
        heading_expect_q.push_back(r);
    endfunction

    task automatic check_heading_beat(input logic [63:0] data, input logic [0:0] user);
        heading_beat_t e;
        if (heading_expect_q.size() == 0) begin
            $error("unexpected result beat: tdata %h tuser %b", data, user);
            n_errors++;
            return;
        end
        e = heading_expect_q.pop_front();
        if (data[HEAD_W-1:0] !== e.heading) begin
            $error("heading: expected %0d, got %0d", e.heading, data[HEAD_W-1:0]);
            n_errors++;
        end
        if (user[0] !== e.valid) begin
            $error("heading_valid: expected %0d, got %0d", e.valid, user[0]);
            n_errors++;
        end
        if (data[HEAD_W +: CW] !== e.cal_x) begin
            $error("cal_x: expected %0d, got %0d", $signed(e.cal_x),
                   $signed(data[HEAD_W +: CW]));
            n_errors++;
        end
        if (data[HEAD_W + CW +: CW] !== e.cal_y) begin
            $error("cal_y: expected %0d, got %0d", $signed(e.cal_y),
                   $signed(data[HEAD_W + CW +: CW]));
            n_errors++;
        end
        if (data[HEAD_W + 2*CW +: CW] !== e.cal_z) begin
            $error("cal_z: expected %0d, got %0d", $signed(e.cal_z),
                   $signed(data[HEAD_W + 2*CW +: CW]));
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, a few long, with calm stretches
    function automatic int pause_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SW-1:0] clamp_sample(input int v);
        if (v > 32767)
            return SW'(32767);
        if (v < -32768)
            return SW'(-32768);
        return SW'(v);
    endfunction

    // sample within +/- spread of the planned offset of one axis
    function automatic logic [SW-1:0] near_offset(input int k, input int spread);
        return clamp_sample(int'($signed(plan_axis[k].off))
                            + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // acquire samples spread out a little more each round, so the offsets
    // sweep across the range instead of pinning at once
    function automatic logic [SW-1:0] acq_sample(input int k, input int p);
        int win;
        win = p * 65535 / N_PHASES;
        if (k == 1)
            return clamp_sample(32767 - int'($urandom_range(0, win)));
        return clamp_sample(-32768 + int'($urandom_range(0, win)));
    endfunction

    function automatic logic [SW-1:0] any_sample();
        return SW'($urandom);
    endfunction

    task automatic queue_beat(input logic [ACT_W-1:0] act, input logic [SW-1:0] x,
                              input logic [SW-1:0] y, input logic [SW-1:0] z);
        compass_beat_t b;
        int k;
        b.act    = act;
        b.smp[0] = x;
        b.smp[1] = y;
        b.smp[2] = z;
        pending_q.push_back(b);
        for (k = 0; k < 3; k++)
            plan_axis[k] = track_axis(plan_axis[k], act, b.smp[k]);
        n_queued++;
    endtask

    task automatic queue_run_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            queue_beat(ACT_RUN, any_sample(), any_sample(), any_sample());
        else if (pick < 65)      // tiny calibrated vectors, zero vector, Y = 0
            queue_beat(ACT_RUN, near_offset(0, 3), near_offset(1, 3), near_offset(2, 3));
        else if (pick < 75)      // calibrated Y exactly zero
            queue_beat(ACT_RUN, any_sample(), plan_axis[1].off, any_sample());
        else if (pick < 85)      // calibrated X exactly zero
            queue_beat(ACT_RUN, plan_axis[0].off, any_sample(), any_sample());
        else
            queue_beat(ACT_RUN, near_offset(0, 2000), near_offset(1, 2000),
                       near_offset(2, 2000));
    endtask

    // ------------------------------------------------------------------
    // Driver: pops pending beats, random gaps between beats. tvalid holds
    // while the block stalls; the beat is predicted at its accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_heading_beat(on_bus);
                beats_in++;
            end
            if (tx_gap > 0 || pending_q.size() == 0) begin
                if (tx_gap > 0)
                    tx_gap--;
                s_tvalid <= 1'b0;
            end else begin
                on_bus = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= on_bus.smp;
                s_tuser  <= on_bus.act;
                tx_gap   = pause_len(tx_quiet);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat, stalls tready at random and once
    // holds it low long enough that the block backs up into its input.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_heading_beat(m_tdata, m_tuser);
                results_seen++;
                rx_stall = pause_len(rx_quiet);
            end
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int p, k, n;
        for (k = 0; k < 3; k++) begin
            pred_axis[k] = '0;
            plan_axis[k] = '0;
        end

        // directed: runs against zero offsets first
        queue_beat(ACT_RUN, 16'd100, 16'd0, 16'd0);               // Y = 0, X > 0: north
        queue_beat(ACT_RUN, -16'sd5, 16'd0, 16'd7);               // Y = 0, X < 0: south
        queue_beat(ACT_RUN, 16'd0, 16'd0, 16'd123);               // zero vector
        queue_beat(ACT_RUN, 16'd0, 16'd50, -16'sd1);              // X = 0, Y > 0
        queue_beat(ACT_RUN, 16'd0, -16'sd50, 16'd1);              // X = 0, Y < 0
        queue_beat(ACT_RUN, 16'h7fff, 16'h8000, 16'h8000);
        queue_beat(ACT_RUN, 16'h8000, 16'h7fff, 16'h7fff);
        queue_beat(ACT_RUN, 16'd1, -16'sd1, 16'hffff);
        queue_beat(ACT_RUN, -16'sd1, 16'd1, 16'd0);
        queue_beat(ACT_UNUSED, 16'hffff, 16'hffff, 16'hffff);     // ignored action
        // zero sample leaves an empty axis empty; calibrate keeps offset 0
        queue_beat(ACT_ACQUIRE, 16'd0, 16'd0, 16'd0);
        queue_beat(ACT_CALIBRATE, 16'hffff, 16'h0000, 16'h5a5a);
        queue_beat(ACT_RUN, 16'd3, 16'd4, 16'd5);
        // first real acquire takes the sample as both ends of the range
        queue_beat(ACT_ACQUIRE, 16'h8000, 16'h7fff, 16'h8000);
        queue_beat(ACT_ACQUIRE, 16'h8000, 16'h7fff, 16'h8000);
        queue_beat(ACT_CALIBRATE, 16'd0, 16'd0, 16'd0);
        queue_beat(ACT_RUN, 16'h7fff, 16'h8000, 16'h7fff);        // full-scale cal values
        queue_beat(ACT_RUN, 16'h8000, 16'h7fff, 16'h8000);        // zero vector again
        queue_beat(ACT_RUN, 16'h8001, 16'h7fff, 16'h8000);        // cal Y = 0, X = 1
        // widen ranges; odd sums check truncation toward zero
        queue_beat(ACT_ACQUIRE, -16'sd30000, 16'sd20000, 16'sd1001);
        queue_beat(ACT_ACQUIRE, -16'sd31000, 16'sd30000, 16'sd0);
        queue_beat(ACT_CALIBRATE, 16'd0, 16'd0, 16'd0);
        queue_beat(ACT_RUN, plan_axis[0].off, plan_axis[1].off, plan_axis[2].off);
        queue_beat(ACT_RUN, any_sample(), any_sample(), any_sample());
        queue_beat(ACT_UNUSED, 16'h1234, 16'h8000, 16'h7fff);

        // random rounds: acquire a spread, calibrate, then mostly runs with
        // some stray beats mixed in
        for (p = 1; p <= N_PHASES; p++) begin
            n = $urandom_range(3, 10);
            repeat (n)
                queue_beat(ACT_ACQUIRE, acq_sample(0, p), acq_sample(1, p), acq_sample(2, p));
            queue_beat(ACT_CALIBRATE, any_sample(), any_sample(), any_sample());
            n = $urandom_range(20, 40);
            repeat (n) begin
                k = $urandom_range(0, 99);
                if (k < 5)
                    queue_beat(ACT_UNUSED, any_sample(), any_sample(), any_sample());
                else if (k < 7)   // calibrate with no fresh acquire
                    queue_beat(ACT_CALIBRATE, any_sample(), any_sample(), any_sample());
                else
                    queue_run_beat();
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (beats_in == n_queued);
        while (heading_expect_q.size() != 0)
            @(posedge aclk);
        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog: well above the slowest legal run (all run beats, long gaps
    // and stalls on every beat, plus the long hold)
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
